/* rtl/bad_pkg.sv */
`timescale 1ns / 1ps
package bad_pkg;

  localparam int DIM_W       = 11;
  localparam int COUNT_W     = 16;
  localparam int GCOL_W      = 7;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 36;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int QUO_W       = 16;
  localparam int ROW_OUT_W   = 10;
  localparam int COL_OUT_W   = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS    = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SETTING = 2'd1,
    STATUS_DIVIDE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_SET_H,
    ST_WAIT_H,
    ST_SET_W,
    ST_WAIT_W,
    ST_SET_AREA,
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [SUM_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/bad_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, quotient must fit QUO_W bits
module bad_div (
  input  logic                clk,
  input  logic                rst,
  input  bad_pkg::div_req_t   req,
  output bad_pkg::div_rsp_t   rsp
);

  localparam int SHIFT_W = bad_pkg::AREA_W + bad_pkg::QUO_W - 1;
  localparam int CMP_W   = (SHIFT_W > bad_pkg::SUM_W) ? SHIFT_W : bad_pkg::SUM_W;
  localparam int STEP_W  = $clog2(bad_pkg::QUO_W);

  logic [bad_pkg::SUM_W-1:0] rem;
  logic [SHIFT_W-1:0]        dsh;
  logic [bad_pkg::QUO_W-1:0] quo;
  logic [STEP_W-1:0]         step;
  logic                      running;
  logic                      done;
  logic                      fits;

  assign fits = CMP_W'(rem) >= CMP_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && step == STEP_W'(bad_pkg::QUO_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsh  <= {req.divisor, {(bad_pkg::QUO_W - 1){1'b0}}};
      step <= '0;
    end else if (running) begin
      if (fits) begin
        rem <= rem - bad_pkg::SUM_W'(dsh);
      end
      quo  <= {quo[bad_pkg::QUO_W-2:0], fits};
      dsh  <= dsh >> 1;
      step <= step + STEP_W'(1);
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* rtl/block_average_downsample.sv */
`timescale 1ns / 1ps
// Block-average downsampler. Unsigned Q1.15 mask samples come in raster order, plane after
// plane; each plane is cut into grid_rows x grid_cols equal cells and the truncated mean of
// every cell is given with its grid row and column, a last-of-plane and a last-of-batch flag.
// The running sums live in a column memory with one 36-bit word per grid column; every
// sample is a read-modify-write of its column's word: it is taken and its word is read in
// ST_IDLE, then added and written back in ST_ACC. A sample that finishes a cell also runs
// the shared bit-serial divider for sum / area, and the block then waits for the result
// register to be free; a sample that does not finish a cell is taken even while a result
// waits. Any write to a register 0..4 restarts the stream at the first sample of the first
// plane and starts a setup pass (two divisions for the cell size, one multiply for the area)
// during which no sample is taken. With a bad configuration every sample gives at once one
// result with an error status and no state changes: status 1 for a zero or oversized
// setting, status 2 for a size that the grid does not divide.
module block_average_downsample #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_GRID_COLS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bad_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bad_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [bad_pkg::SAMPLE_W-1:0]      sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [bad_pkg::QUO_W-1:0]         cell_mean,
  output logic [bad_pkg::ROW_OUT_W-1:0]     cell_row,
  output logic [bad_pkg::COL_OUT_W-1:0]     cell_col,
  output logic                              last_of_plane,
  output logic                              last_of_batch,
  output logic [1:0]                        status
);

  // counter widths follow the size limits
  localparam int X_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_W = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;

  // configuration registers
  logic [bad_pkg::COUNT_W-1:0] plane_count;
  logic [bad_pkg::DIM_W-1:0]   image_height;
  logic [bad_pkg::DIM_W-1:0]   image_width;
  logic [bad_pkg::DIM_W-1:0]   grid_rows;
  logic [bad_pkg::GCOL_W-1:0]  grid_cols;
  logic                        cfg_hit;
  logic                        setting_bad;

  // derived at setup
  logic [bad_pkg::DIM_W-1:0]   cell_h;
  logic [bad_pkg::DIM_W-1:0]   cell_w;
  logic [bad_pkg::AREA_W-1:0]  area;
  logic                        rem_h_nz;
  logic                        rem_w_nz;
  bad_pkg::status_t            cfg_status;

  // stream position
  logic [X_W-1:0]              pixel_x;
  logic [X_W-1:0]              within_x;
  logic [Y_W-1:0]              pixel_y;
  logic [Y_W-1:0]              within_y;
  logic [COL_W-1:0]            grid_col;
  logic [Y_W-1:0]              grid_row;
  logic [bad_pkg::COUNT_W-1:0] plane_idx;

  // end-of-span flags of the current position
  logic                        x_cell_end;
  logic                        x_row_end;
  logic                        y_cell_end;
  logic                        y_plane_end;
  logic                        batch_end;

  // word in flight
  logic [bad_pkg::SAMPLE_W-1:0] item_sample;
  logic                         item_first;
  logic                         item_last;
  logic [COL_W-1:0]             item_col;
  logic [Y_W-1:0]               item_row;
  logic                         item_end_plane;
  logic                         item_end_batch;

  // column memory
  logic [bad_pkg::SUM_W-1:0]    sums [MAX_GRID_COLS];
  logic [bad_pkg::SUM_W-1:0]    rd_data;
  logic [bad_pkg::SUM_W-1:0]    new_sum;
  logic                         mem_we;

  // control
  bad_pkg::state_t              state;
  bad_pkg::state_t              state_next;
  bad_pkg::div_req_t            div_req;
  bad_pkg::div_rsp_t            div_rsp;
  logic                         slot_free;
  logic                         accept_ok;
  logic                         accept_err;
  logic                         out_load;

  // any write to a listed register
  always_comb begin
    case (cfg_index)
      bad_pkg::REG_PLANE_COUNT,
      bad_pkg::REG_IMAGE_HEIGHT,
      bad_pkg::REG_IMAGE_WIDTH,
      bad_pkg::REG_GRID_ROWS,
      bad_pkg::REG_GRID_COLS: cfg_hit = cfg_write;
      default:                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count  <= bad_pkg::COUNT_W'(1);
      image_height <= bad_pkg::DIM_W'(1);
      image_width  <= bad_pkg::DIM_W'(1);
      grid_rows    <= bad_pkg::DIM_W'(1);
      grid_cols    <= bad_pkg::GCOL_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        bad_pkg::REG_PLANE_COUNT:  plane_count  <= cfg_data;
        bad_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[bad_pkg::DIM_W-1:0];
        bad_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bad_pkg::DIM_W-1:0];
        bad_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data[bad_pkg::DIM_W-1:0];
        bad_pkg::REG_GRID_COLS:    grid_cols    <= cfg_data[bad_pkg::GCOL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero or oversized settings need no division
  assign setting_bad = (plane_count == '0) || (image_height == '0) || (image_width == '0) ||
                       (grid_rows == '0) || (grid_cols == '0) ||
                       (32'(image_height) > 32'(MAX_HEIGHT)) ||
                       (32'(image_width) > 32'(MAX_WIDTH)) ||
                       (32'(grid_cols) > 32'(MAX_GRID_COLS));

  // position flags, valid while the configuration is good
  assign x_cell_end  = 32'(within_x) == 32'(cell_w) - 32'd1;
  assign x_row_end   = 32'(pixel_x) == 32'(image_width) - 32'd1;
  assign y_cell_end  = 32'(within_y) == 32'(cell_h) - 32'd1;
  assign y_plane_end = 32'(pixel_y) == 32'(image_height) - 32'd1;
  assign batch_end   = 32'(plane_idx) == 32'(plane_count) - 32'd1;

  assign slot_free  = !result_valid || result_ready;
  assign new_sum    = item_first ? bad_pkg::SUM_W'(item_sample)
                                 : rd_data + bad_pkg::SUM_W'(item_sample);
  assign accept_ok  = sample_valid && sample_ready && (cfg_status == bad_pkg::STATUS_OK);
  assign accept_err = sample_valid && sample_ready && (cfg_status != bad_pkg::STATUS_OK);

  // sequencer: setup pass, then one word at a time through the column memory
  always_comb begin
    state_next       = state;
    sample_ready     = 1'b0;
    mem_we           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = bad_pkg::SUM_W'(image_height);
    div_req.divisor  = bad_pkg::AREA_W'(grid_rows);
    case (state)
      bad_pkg::ST_SET_H: begin
        div_req.start = 1'b1;
        state_next    = bad_pkg::ST_WAIT_H;
      end
      bad_pkg::ST_WAIT_H: begin
        if (div_rsp.done) begin
          state_next = bad_pkg::ST_SET_W;
        end
      end
      bad_pkg::ST_SET_W: begin
        div_req.start    = 1'b1;
        div_req.dividend = bad_pkg::SUM_W'(image_width);
        div_req.divisor  = bad_pkg::AREA_W'(grid_cols);
        state_next       = bad_pkg::ST_WAIT_W;
      end
      bad_pkg::ST_WAIT_W: begin
        if (div_rsp.done) begin
          state_next = bad_pkg::ST_SET_AREA;
        end
      end
      bad_pkg::ST_SET_AREA: begin
        state_next = bad_pkg::ST_IDLE;
      end
      bad_pkg::ST_IDLE: begin
        // error words go straight to the result register
        sample_ready = (cfg_status == bad_pkg::STATUS_OK) || slot_free;
        if (sample_valid && (cfg_status == bad_pkg::STATUS_OK)) begin
          state_next = bad_pkg::ST_ACC;
        end
      end
      bad_pkg::ST_ACC: begin
        mem_we           = 1'b1;
        div_req.dividend = new_sum;
        div_req.divisor  = area;
        if (item_last) begin
          div_req.start = 1'b1;
          state_next    = bad_pkg::ST_DIV;
        end else begin
          state_next = bad_pkg::ST_IDLE;
        end
      end
      bad_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = bad_pkg::ST_HOLD;
        end
      end
      bad_pkg::ST_HOLD: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = bad_pkg::ST_IDLE;
        end
      end
      default: state_next = bad_pkg::ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_next = bad_pkg::ST_SET_H;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  bad_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // cell size, area and status; reset values describe the reset configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_h     <= bad_pkg::DIM_W'(1);
      cell_w     <= bad_pkg::DIM_W'(1);
      rem_h_nz   <= 1'b0;
      rem_w_nz   <= 1'b0;
      area       <= bad_pkg::AREA_W'(1);
      cfg_status <= bad_pkg::STATUS_OK;
    end else begin
      if (state == bad_pkg::ST_WAIT_H && div_rsp.done) begin
        cell_h   <= bad_pkg::DIM_W'(div_rsp.quotient);
        rem_h_nz <= |div_rsp.remainder;
      end
      if (state == bad_pkg::ST_WAIT_W && div_rsp.done) begin
        cell_w   <= bad_pkg::DIM_W'(div_rsp.quotient);
        rem_w_nz <= |div_rsp.remainder;
      end
      if (state == bad_pkg::ST_SET_AREA) begin
        area <= bad_pkg::AREA_W'(bad_pkg::AREA_W'(cell_h) * bad_pkg::AREA_W'(cell_w));
        if (setting_bad) begin
          cfg_status <= bad_pkg::STATUS_SETTING;
        end else if (rem_h_nz || rem_w_nz) begin
          cfg_status <= bad_pkg::STATUS_DIVIDE;
        end else begin
          cfg_status <= bad_pkg::STATUS_OK;
        end
      end
    end
  end

  // raster position moves on as a word is taken
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pixel_x   <= '0;
      within_x  <= '0;
      pixel_y   <= '0;
      within_y  <= '0;
      grid_col  <= '0;
      grid_row  <= '0;
      plane_idx <= '0;
    end else if (accept_ok) begin
      if (x_row_end) begin
        pixel_x  <= '0;
        within_x <= '0;
        grid_col <= '0;
        if (y_plane_end) begin
          pixel_y   <= '0;
          within_y  <= '0;
          grid_row  <= '0;
          plane_idx <= batch_end ? '0 : plane_idx + bad_pkg::COUNT_W'(1);
        end else begin
          pixel_y <= pixel_y + Y_W'(1);
          if (y_cell_end) begin
            within_y <= '0;
            grid_row <= grid_row + Y_W'(1);
          end else begin
            within_y <= within_y + Y_W'(1);
          end
        end
      end else begin
        pixel_x <= pixel_x + X_W'(1);
        if (x_cell_end) begin
          within_x <= '0;
          grid_col <= grid_col + COL_W'(1);
        end else begin
          within_x <= within_x + X_W'(1);
        end
      end
    end
  end

  // capture the word and what its position says about it
  always_ff @(posedge clk) begin
    if (accept_ok) begin
      item_sample    <= sample;
      item_first     <= (within_x == '0) && (within_y == '0);
      item_last      <= x_cell_end && y_cell_end;
      item_col       <= grid_col;
      item_row       <= grid_row;
      item_end_plane <= (32'(grid_row) == 32'(grid_rows) - 32'd1) &&
                        (32'(grid_col) == 32'(grid_cols) - 32'd1);
      item_end_batch <= (32'(grid_row) == 32'(grid_rows) - 32'd1) &&
                        (32'(grid_col) == 32'(grid_cols) - 32'd1) && batch_end;
    end
  end

  // column sums: read as the word is taken, written back the next cycle
  always_ff @(posedge clk) begin
    if (accept_ok) begin
      rd_data <= sums[grid_col];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums[item_col] <= new_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load || accept_err) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_mean     <= div_rsp.quotient;
      cell_row      <= bad_pkg::ROW_OUT_W'(item_row);
      cell_col      <= bad_pkg::COL_OUT_W'(item_col);
      last_of_plane <= item_end_plane;
      last_of_batch <= item_end_batch;
      status        <= bad_pkg::STATUS_OK;
    end else if (accept_err) begin
      cell_mean     <= '0;
      cell_row      <= '0;
      cell_col      <= '0;
      last_of_plane <= 1'b0;
      last_of_batch <= 1'b0;
      status        <= cfg_status;
    end
  end

endmodule

/* bench/tb_block_average_downsample.sv */
`timescale 1ns / 1ps
module tb_block_average_downsample;

  // limits the block is built with, repeated here for the grid check
  localparam int PLANE_MAX_H   = 1024;
  localparam int PLANE_MAX_W   = 1024;
  localparam int GRID_MAX_COLS = 64;
  localparam int SLOT_W        = $clog2(GRID_MAX_COLS);

  // register indexes past the end of the list, writes there are dropped
  localparam logic [bad_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [bad_pkg::CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam int SETTLE_CYCLES    = 48;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT      = 1000000;

  typedef struct packed {
    logic [bad_pkg::QUO_W-1:0]     mean;
    logic [bad_pkg::ROW_OUT_W-1:0] row;
    logic [bad_pkg::COL_OUT_W-1:0] col;
    logic                          plane_end;
    logic                          batch_end;
    bad_pkg::status_t              code;
  } cell_result_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            cfg_write    = 1'b0;
  logic [bad_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [bad_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                            sample_valid = 1'b0;
  logic                            sample_ready;
  logic [bad_pkg::SAMPLE_W-1:0]    sample       = '0;
  logic                            result_valid;
  logic                            result_ready = 1'b0;
  logic [bad_pkg::QUO_W-1:0]       cell_mean;
  logic [bad_pkg::ROW_OUT_W-1:0]   cell_row;
  logic [bad_pkg::COL_OUT_W-1:0]   cell_col;
  logic                            last_of_plane;
  logic                            last_of_batch;
  logic [1:0]                      status;

  // shared between the stimulus, the result sink and the watchdog
  bit gaps_on       = 1'b1;
  bit long_hold_req = 1'b0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  // cell results still owed by the block, oldest first
  cell_result_t pending_cells[$];

  // predictor copy of the registers, reset values all one
  logic [bad_pkg::COUNT_W-1:0] cfg_planes    = bad_pkg::COUNT_W'(1);
  logic [bad_pkg::DIM_W-1:0]   cfg_height    = bad_pkg::DIM_W'(1);
  logic [bad_pkg::DIM_W-1:0]   cfg_width     = bad_pkg::DIM_W'(1);
  logic [bad_pkg::DIM_W-1:0]   cfg_grid_rows = bad_pkg::DIM_W'(1);
  logic [bad_pkg::GCOL_W-1:0]  cfg_grid_cols = bad_pkg::GCOL_W'(1);

  // predictor copy of the stream position and the column sums
  logic [bad_pkg::SUM_W-1:0] col_sum [GRID_MAX_COLS];
  int unsigned pos_x = 0, pos_y = 0, in_cell_x = 0, in_cell_y = 0;
  int unsigned grid_c = 0, grid_r = 0, plane_n = 0;

  block_average_downsample #(
    .MAX_WIDTH    (PLANE_MAX_W),
    .MAX_HEIGHT   (PLANE_MAX_H),
    .MAX_GRID_COLS(GRID_MAX_COLS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cell_mean    (cell_mean),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .last_of_plane(last_of_plane),
    .last_of_batch(last_of_batch),
    .status       (status)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // zero or oversized settings win over sizes that do not divide
  function automatic bad_pkg::status_t grid_status();
    if (cfg_planes == '0 || cfg_height == '0 || cfg_width == '0 ||
        cfg_grid_rows == '0 || cfg_grid_cols == '0)
      return bad_pkg::STATUS_SETTING;
    if (32'(cfg_height) > PLANE_MAX_H || 32'(cfg_width) > PLANE_MAX_W ||
        32'(cfg_grid_cols) > GRID_MAX_COLS)
      return bad_pkg::STATUS_SETTING;
    if ((32'(cfg_height) % 32'(cfg_grid_rows)) != 0 ||
        (32'(cfg_width) % 32'(cfg_grid_cols)) != 0)
      return bad_pkg::STATUS_DIVIDE;
    return bad_pkg::STATUS_OK;
  endfunction

  // any write to a real register also rewinds the stream to the first sample
  task automatic apply_reg(input logic [bad_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bad_pkg::CFG_DATA_W-1:0] value);
    bit known;
    known = 1'b1;
    case (idx)
      bad_pkg::REG_PLANE_COUNT:  cfg_planes    = value;
      bad_pkg::REG_IMAGE_HEIGHT: cfg_height    = value[bad_pkg::DIM_W-1:0];
      bad_pkg::REG_IMAGE_WIDTH:  cfg_width     = value[bad_pkg::DIM_W-1:0];
      bad_pkg::REG_GRID_ROWS:    cfg_grid_rows = value[bad_pkg::DIM_W-1:0];
      bad_pkg::REG_GRID_COLS:    cfg_grid_cols = value[bad_pkg::GCOL_W-1:0];
      default:                   known = 1'b0;
    endcase
    if (known) begin
      pos_x     = 0;
      pos_y     = 0;
      in_cell_x = 0;
      in_cell_y = 0;
      grid_c    = 0;
      grid_r    = 0;
      plane_n   = 0;
    end
  endtask

  // one accepted word: queue an error word under a bad grid, else accumulate into its column and queue the cell mean
  task automatic predict_cell(input logic [bad_pkg::SAMPLE_W-1:0] value);
    cell_result_t      r;
    bad_pkg::status_t  code;
    int unsigned       cell_h, cell_w;
    logic [SLOT_W-1:0] slot;
    longint unsigned   area, quotient;
    code = grid_status();
    r    = '0;
    if (code != bad_pkg::STATUS_OK) begin
      // bad grid: error word per sample, position untouched
      r.code = code;
      pending_cells.push_back(r);
    end else begin
      cell_h = 32'(cfg_height) / 32'(cfg_grid_rows);
      cell_w = 32'(cfg_width) / 32'(cfg_grid_cols);
      slot   = (grid_c >= GRID_MAX_COLS) ? SLOT_W'(GRID_MAX_COLS - 1) : SLOT_W'(grid_c);
      // first sample of a cell overwrites the column sum
      if (in_cell_x == 0 && in_cell_y == 0)
        col_sum[slot] = bad_pkg::SUM_W'(value);
      else
        col_sum[slot] = col_sum[slot] + bad_pkg::SUM_W'(value);
      if (in_cell_x == cell_w - 1 && in_cell_y == cell_h - 1) begin
        area        = 64'(cell_h) * 64'(cell_w);
        quotient    = 64'(col_sum[slot]) / area;
        r.mean      = quotient[bad_pkg::QUO_W-1:0];
        r.row       = grid_r[bad_pkg::ROW_OUT_W-1:0];
        r.col       = grid_c[bad_pkg::COL_OUT_W-1:0];
        r.plane_end = (grid_r == 32'(cfg_grid_rows) - 1) &&
                      (grid_c == 32'(cfg_grid_cols) - 1);
        r.batch_end = r.plane_end && (plane_n == 32'(cfg_planes) - 1);
        r.code      = bad_pkg::STATUS_OK;
        pending_cells.push_back(r);
      end
      // raster walk: column, then row, then plane, wrapping at end of batch
      pos_x++;
      in_cell_x++;
      if (in_cell_x >= cell_w) begin
        in_cell_x = 0;
        grid_c++;
      end
      if (pos_x >= 32'(cfg_width)) begin
        pos_x     = 0;
        in_cell_x = 0;
        grid_c    = 0;
        pos_y++;
        in_cell_y++;
        if (in_cell_y >= cell_h) begin
          in_cell_y = 0;
          grid_r++;
        end
        if (pos_y >= 32'(cfg_height)) begin
          pos_y     = 0;
          in_cell_y = 0;
          grid_r    = 0;
          plane_n++;
          if (plane_n >= 32'(cfg_planes)) plane_n = 0;
        end
      end
    end
  endtask

  // ------------------------------------------------------------------ checker

  task automatic compare_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, label, want, got);
    end
  endtask

  task automatic check_result();
    cell_result_t want;
    if (pending_cells.size() == 0) begin
      mismatch_count++;
      $display("%0t: result word with none expected, got mean %0d row %0d col %0d status %0d",
               $time, cell_mean, cell_row, cell_col, status);
    end else begin
      want = pending_cells.pop_front();
      compare_field("cell_mean", want.mean, cell_mean);
      compare_field("cell_row", 16'(want.row), 16'(cell_row));
      compare_field("cell_col", 16'(want.col), 16'(cell_col));
      compare_field("last_of_plane", 16'(want.plane_end), 16'(last_of_plane));
      compare_field("last_of_batch", 16'(want.batch_end), 16'(last_of_batch));
      compare_field("status", 16'(want.code), 16'(status));
    end
  endtask

  // everything is sampled at the rising edge, before any update of this step;
  // a word accepted on the same edge as a result is predicted first
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (sample_valid && sample_ready) predict_cell(sample);
      if (result_valid && result_ready) check_result();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result sink: random stall bursts, or one long hold when asked for
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        stall = $urandom_range(1, 12);
        repeat (stall) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- sender side

  // offer one word and hold it until taken; valid stays up between words
  // unless an idle burst is drawn
  task automatic offer_sample(input logic [bad_pkg::SAMPLE_W-1:0] value);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (!(sample_valid && sample_ready));
  endtask

  // mostly in-range mask values, with the corners and full 16-bit noise
  function automatic logic [bad_pkg::SAMPLE_W-1:0] next_sample_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // stop offering and wait until every owed cell has come back
  task automatic pause_stream();
    sample_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  // block fully idle: nothing owed and any result-less word finished
  task automatic settle_stream();
    pause_stream();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write enable left high between back-to-back writes, lowered by the caller
  task automatic write_reg(input logic [bad_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bad_pkg::CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // values wider than the data port lose their upper bits on the way in
  task automatic load_grid(input int unsigned planes, input int unsigned height,
                           input int unsigned width, input int unsigned rows,
                           input int unsigned cols);
    settle_stream();
    write_reg(bad_pkg::REG_PLANE_COUNT, bad_pkg::CFG_DATA_W'(planes));
    write_reg(bad_pkg::REG_IMAGE_HEIGHT, bad_pkg::CFG_DATA_W'(height));
    write_reg(bad_pkg::REG_IMAGE_WIDTH, bad_pkg::CFG_DATA_W'(width));
    write_reg(bad_pkg::REG_GRID_ROWS, bad_pkg::CFG_DATA_W'(rows));
    write_reg(bad_pkg::REG_GRID_COLS, bad_pkg::CFG_DATA_W'(cols));
    cfg_write <= 1'b0;
  endtask

  // small legal grid; wide grids get narrow cells to keep planes short
  task automatic load_random_grid(output int unsigned batch_len);
    int unsigned cell_h, cell_w, rows, cols, planes;
    cell_h = $urandom_range(1, 4);
    rows   = $urandom_range(1, 4);
    cols   = ($urandom_range(0, 5) == 0) ? $urandom_range(9, GRID_MAX_COLS)
                                         : $urandom_range(1, 8);
    cell_w = (cols > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
    planes = $urandom_range(1, 3);
    load_grid(planes, cell_h * rows, cell_w * cols, rows, cols);
    batch_len = planes * cell_h * rows * cell_w * cols;
  endtask

  // -------------------------------------------------------------------- tests

  // reset grid is 1x1 with one plane: every word is its own cell
  task automatic test_default_grid();
    offer_sample(16'h0000);
    offer_sample(16'h8000);
    offer_sample(16'hFFFF);
    offer_sample(16'hAAAA);
    offer_sample(16'h5555);
  endtask

  // each kind of broken setting, one word apiece
  task automatic test_bad_settings();
    int unsigned bad_grids [13][5] = '{
      '{0, 1, 1, 1, 1}, '{1, 0, 1, 1, 1}, '{1, 1, 0, 1, 1}, '{1, 1, 1, 0, 1},
      '{1, 1, 1, 1, 0}, '{1, 1025, 1, 1, 1}, '{1, 1, 'hFFFF, 1, 1},
      '{1, 1, 65, 1, 65}, '{1, 1, 127, 1, 127}, '{1, 3, 1, 2, 1},
      '{1, 1, 5, 1, 3}, '{1, 2, 1, 4, 1}, '{1, 1025, 5, 2, 3}
    };
    foreach (bad_grids[i]) begin
      load_grid(bad_grids[i][0], bad_grids[i][1], bad_grids[i][2],
                bad_grids[i][3], bad_grids[i][4]);
      offer_sample(next_sample_value());
    end
  endtask

  // two planes of 2x2 in 1x2 cells: plane and batch flags, wrap to a new
  // batch, truncation, register masking and writes to spare indexes
  task automatic test_batch_flags();
    // upper data bits beyond each register width must be dropped
    load_grid(2, 'hF802, 2, 2, 'hFF81);
    offer_sample(16'd1);
    offer_sample(16'd2);
    offer_sample(16'hFFFF);
    // mid-cell: spare writes must leave the stream position alone
    settle_stream();
    write_reg(REG_SPARE_FIRST, 16'hFFFF);
    write_reg(REG_SPARE_LAST, 16'h0000);
    cfg_write <= 1'b0;
    offer_sample(16'hFFFF);
    offer_sample(16'h0000);
    offer_sample(16'h8000);
    offer_sample(16'd3);
    offer_sample(16'd4);
    offer_sample(16'd7);
    offer_sample(16'd8);
  endtask

  // most grid columns, first rows of the tallest grid, a large cell and
  // the largest legal sizes
  task automatic test_extreme_sizes();
    load_grid(1, 1, GRID_MAX_COLS, 1, GRID_MAX_COLS);
    repeat (GRID_MAX_COLS) offer_sample(next_sample_value());
    load_grid('hFFFF, PLANE_MAX_H, 1, PLANE_MAX_H, 1);
    repeat (64) offer_sample(next_sample_value());
    // one 16x16 cell of full-scale words
    load_grid(1, 16, 16, 1, 1);
    repeat (256) offer_sample(16'hFFFF);
    load_grid(1, PLANE_MAX_H, PLANE_MAX_W, PLANE_MAX_H, GRID_MAX_COLS);
    repeat (GRID_MAX_COLS) offer_sample(next_sample_value());
  endtask

  // every word finishes a cell, so a long sink hold backs up the input;
  // then the sender stops until all cells are back and carries on
  task automatic test_backpressure();
    load_grid(1, 8, 8, 8, 8);
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (80) offer_sample(next_sample_value());
    pause_stream();
    repeat (40) offer_sample(next_sample_value());
    gaps_on = 1'b1;
  endtask

  // legal grids with random words, some register noise in between
  task automatic test_random_grids(input int unsigned target);
    int unsigned sent, batch_len, run;
    sent = 0;
    while (sent < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        load_grid($urandom, $urandom, $urandom, $urandom, $urandom);
        run = $urandom_range(2, 6);
      end else begin
        load_random_grid(batch_len);
        run = (batch_len <= 200) ? batch_len * $urandom_range(1, 2)
                                 : $urandom_range(50, 200);
      end
      repeat (run) offer_sample(next_sample_value());
      sent += run;
    end
    gaps_on = 1'b1;
  endtask

  // last stretch runs flat out on both sides
  task automatic test_steady_tail();
    int unsigned batch_len;
    load_random_grid(batch_len);
    gaps_on = 1'b0;
    repeat (200) offer_sample(next_sample_value());
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_grid();
    test_bad_settings();
    test_batch_flags();
    test_extreme_sizes();
    test_backpressure();
    test_random_grids(700);
    test_steady_tail();
    settle_stream();
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
